>>> hdl/swrms_pkg.sv
`default_nettype none
package swrms_pkg;
  localparam int DEF_MAX_WINDOW  = 8192;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int CFG_W    = 14;
  localparam int FLOOR_W  = 9;
  localparam int LEVEL_W  = 17;
  localparam logic [0:0] REG_WINDOW = 1'b0;
  localparam logic [0:0] REG_FLOOR  = 1'b1;
  localparam logic [36:0] DB_SCALE_Q = 37'd50504453;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_UPD, ST_LOGS, ST_LOGW, ST_MUL, ST_OUT
  } back_st_t;

  typedef enum logic [1:0] {
    CL_IDLE, CL_RUN
  } clr_st_t;
endpackage
`default_nettype wire

>>> hdl/swrms_log2.sv
`default_nettype none
module swrms_log2
  import swrms_pkg::*;
#(
  parameter int XW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [XW-1:0] x,
  output logic               done,
  output logic [23:0]        result
);
  localparam int NW = $clog2(XW);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} lst_t;
  lst_t st_r, st_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [32:0]   y_r, y_nxt;
  logic [15:0]   frac_r, frac_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          done_nxt;
  logic [65:0]   sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
      done <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done <= done_nxt;
    end
    x_r    <= x_nxt;
    n_r    <= n_nxt;
    y_r    <= y_nxt;
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign sq = y_r * y_r;
  assign result = {{(8 - NW){1'b0}}, n_r, frac_r};

  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    n_nxt    = n_r;
    y_nxt    = y_r;
    frac_nxt = frac_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    case (st_r)
      L_IDLE: begin
        if (start) begin
          x_nxt = x;
          n_nxt = NW'(XW - 1);
          st_nxt = L_NORM;
        end
      end
      L_NORM: begin
        if (x_r[XW-1] || n_r == '0) begin
          y_nxt = {1'b0, x_r[XW-1 -: 32]};
          if (XW < 32) y_nxt = 33'(x_r) << (32 - XW);
          frac_nxt = '0;
          cnt_nxt = '0;
          st_nxt = L_SQ;
        end else begin
          x_nxt = x_r << 1;
          n_nxt = n_r - 1'b1;
        end
      end
      L_SQ: begin
        frac_nxt = {frac_r[14:0], sq[63]};
        y_nxt = sq[63] ? {1'b0, sq[63:32]} : {1'b0, sq[62:31]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd15) begin
          st_nxt = L_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: st_nxt = L_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/swrms_front.sv
`default_nettype none
module swrms_front
  import swrms_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int SQ_W = 2 * SAMPLE_BITS - 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic                        q_valid,
  output logic [SQ_W-1:0]             q_sq,
  input  wire logic                   q_take,
  input  wire logic                   hold
);
  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0] sq_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic wr, rd;

  always_comb begin
    mag = in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
  end

  assign in_full = (cnt_r == 2'd2) || hold;
  assign wr = in_push && !in_full;
  assign rd = q_take && q_valid;
  assign q_valid = cnt_r != 2'd0;
  assign q_sq = sq_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
    end
    if (wr) sq_r[wp_r] <= SQ_W'(mag) * SQ_W'(mag);
  end
endmodule
`default_nettype wire

>>> hdl/swrms_back.sv
`default_nettype none
module swrms_back
  import swrms_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int SQ_W = 2 * SAMPLE_BITS - 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire logic [SQ_W-1:0]       q_sq,
  output logic                       q_take,
  input  wire logic                  clr_start,
  input  wire logic [CFG_W-1:0]      win,
  input  wire logic signed [FLOOR_W-1:0] floor_db,
  output logic                       busy,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic signed [LEVEL_W-1:0]  out_level_db,
  output logic                       out_at_floor
);
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int SUMW = SQ_W + AW;
  localparam int LW   = 64;

  logic [SQ_W-1:0] ring [MAX_WINDOW];
  logic [SQ_W-1:0] rd_r;
  logic [AW-1:0]   pos_r, pos_nxt, clr_r;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0] sq_r, sq_nxt;
  logic            clearing_r;
  back_st_t        st_r, st_nxt;
  logic [23:0]     ls_r, ls_nxt;
  logic            log_start;
  logic [LW-1:0]   log_x;
  logic            log_done;
  logic [23:0]     log_res;
  logic [24:0]     m_r, m_nxt;
  logic [62:0]     prod;
  logic            neg_r, neg_nxt;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [SQ_W-1:0] wr_data;
  logic signed [LEVEL_W-1:0] lvl_r, lvl_nxt, fl;
  logic            flg_r, flg_nxt;
  logic            full_r, full_nxt;
  logic signed [FLOOR_W-1:0] flc;
  logic signed [25:0] d;
  logic signed [LEVEL_W:0] lv;

  assign busy = clearing_r;
  assign out_empty = !full_r;
  assign out_level_db = lvl_r;
  assign out_at_floor = flg_r;

  always_comb begin
    flc = floor_db;
    if (floor_db < -9'sd144) flc = -9'sd144;
    if (floor_db > 9'sd0) flc = '0;
    fl = LEVEL_W'(flc) <<< 8;
  end

  always_comb begin
    if (clearing_r) begin
      wr_en = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else begin
      wr_en = st_r == ST_UPD;
      wr_addr = pos_r;
      wr_data = sq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) ring[wr_addr] <= wr_data;
    rd_r <= ring[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      clearing_r <= 1'b1;
      clr_r <= '0;
      pos_r <= '0;
      sum_r <= '0;
      full_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      full_r <= full_nxt;
      if (clr_start) begin
        clearing_r <= 1'b1;
        clr_r <= '0;
      end else if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == AW'(MAX_WINDOW - 1)) clearing_r <= 1'b0;
      end
    end
    sq_r <= sq_nxt;
    ls_r <= ls_nxt;
    m_r <= m_nxt;
    neg_r <= neg_nxt;
    lvl_r <= lvl_nxt;
    flg_r <= flg_nxt;
  end

  swrms_log2 #(.XW(LW)) u_log (
    .clk(clk), .rst_n(rst_n), .start(log_start), .x(log_x),
    .done(log_done), .result(log_res)
  );

  assign prod = m_r * DB_SCALE_Q;
  assign d = $signed({2'b0, ls_r}) - $signed({2'b0, log_res})
           - $signed(26'(2 * (SAMPLE_BITS - 1) * 65536));

  always_comb begin
    st_nxt = st_r;
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    sq_nxt = sq_r;
    ls_nxt = ls_r;
    m_nxt = m_r;
    neg_nxt = neg_r;
    lvl_nxt = lvl_r;
    flg_nxt = flg_r;
    full_nxt = full_r;
    q_take = 1'b0;
    log_start = 1'b0;
    log_x = LW'(sum_r);
    lv = '0;
    if (out_pop && full_r) full_nxt = 1'b0;
    if (clr_start) begin
      pos_nxt = '0;
      sum_nxt = '0;
    end
    case (st_r)
      ST_IDLE: begin
        if (q_valid && !clearing_r && !clr_start && !full_r) begin
          q_take = 1'b1;
          sq_nxt = q_sq;
          st_nxt = ST_READ;
        end
      end
      ST_READ: st_nxt = ST_UPD;
      ST_UPD: begin
        sum_nxt = sum_r - SUMW'(rd_r) + SUMW'(sq_r);
        pos_nxt = (32'(pos_r) + 1 >= 32'(win)) ? '0 : pos_r + 1'b1;
        st_nxt = ST_LOGS;
        if (sum_nxt != '0) log_start = 1'b1;
        log_x = LW'(sum_nxt);
        if (sum_nxt == '0) begin
          lvl_nxt = fl;
          flg_nxt = 1'b1;
          st_nxt = ST_OUT;
        end
      end
      ST_LOGS: begin
        if (log_done) begin
          ls_nxt = log_res;
          log_start = 1'b1;
          log_x = LW'(win);
          st_nxt = ST_LOGW;
        end
      end
      ST_LOGW: begin
        if (log_done) begin
          neg_nxt = !d[25];
          m_nxt = 25'(-d);
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (neg_r) lv = '0;
        else lv = -$signed({1'b0, LEVEL_W'((prod + 63'h80000000) >> 32)});
        if (lv < (LEVEL_W + 1)'(fl)) begin
          lvl_nxt = fl;
          flg_nxt = 1'b1;
        end else begin
          lvl_nxt = LEVEL_W'(lv);
          flg_nxt = 1'b0;
        end
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!full_r || out_pop) begin
          full_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/sliding_window_rms_db_core.sv
// Result path: a zero window sum goes straight to the output, else two log2 passes
// (over sum and window, each lengthened by the leading zeros of its input) come first.
// One sample is processed at a time; the next is taken only once the last result is popped.
// Reset (synchronous, rst_n low): window 2048, floor -100 dB, then a clearing
// pass over every entry of the square ring; same pass on a window change.
`default_nettype none
module sliding_window_rms_db_core
  import swrms_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [SAMPLE_BITS-1:0]    in_sample,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic signed [LEVEL_W-1:0]      out_level_db,
  output logic                           out_at_floor,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data
);
  localparam int SQ_W = 2 * SAMPLE_BITS - 1;
  logic [CFG_W-1:0] win_r, eff_new;
  logic signed [FLOOR_W-1:0] floor_r;
  logic clr_start, busy, q_valid, q_take;
  logic [SQ_W-1:0] q_sq;

  always_comb begin
    eff_new = cfg_data;
    if (cfg_data == '0) eff_new = CFG_W'(1);
    if (32'(cfg_data) > MAX_WINDOW) eff_new = CFG_W'(MAX_WINDOW);
  end
  assign clr_start = cfg_we && cfg_index == REG_WINDOW && eff_new != win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= CFG_W'(2048 > MAX_WINDOW ? MAX_WINDOW : 2048);
      floor_r <= -9'sd100;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW) win_r <= eff_new;
      else floor_r <= cfg_data[FLOOR_W-1:0];
    end
  end

  swrms_front #(.SAMPLE_BITS(SAMPLE_BITS), .SQ_W(SQ_W)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_sample(in_sample), .q_valid(q_valid), .q_sq(q_sq),
    .q_take(q_take), .hold(busy)
  );

  swrms_back #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .SQ_W(SQ_W)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_sq(q_sq), .q_take(q_take),
    .clr_start(clr_start), .win(win_r), .floor_db(floor_r), .busy(busy),
    .out_empty(out_empty), .out_pop(out_pop), .out_level_db(out_level_db),
    .out_at_floor(out_at_floor)
  );

`ifndef ASSERT_OFF
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_level_db <= 0) else $error("level above 0 dB");
  a_no_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_full) else $error("accepting during clear");
`endif
endmodule
`default_nettype wire
